// ===== hdl/euler_to_quaternion_defines.svh =====
// Assertion macros for the checker file of the Euler to quaternion block.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// Same-cycle implication, muted while reset is held
`define E2Q_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is held
`define E2Q_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/e2q_pkg.sv =====
// Types, constants and the arctangent table of the Euler to quaternion block.
`default_nettype none
package e2q_pkg;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ZW               = 33;

    localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [ZW-1:0] Q30_GAIN  = 33'sd652032874;

    typedef struct packed {
        logic signed [ZW-1:0] x;
        logic signed [ZW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_lane;

    typedef t_lane [2:0] t_lanes;

    // atan(2^-i) in Q.30, truncated; zero past the table
    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 33'sh03243F6A8;
            1:  v = 33'sh01DAC6705;
            2:  v = 33'sh00FADBAFC;
            3:  v = 33'sh007F56EA6;
            4:  v = 33'sh003FEAB76;
            5:  v = 33'sh001FFD55B;
            6:  v = 33'sh000FFFAAA;
            7:  v = 33'sh0007FFF55;
            8:  v = 33'sh0003FFFEA;
            9:  v = 33'sh0001FFFFD;
            10: v = 33'sh0000FFFFF;
            11: v = 33'sh00007FFFF;
            12: v = 33'sh00003FFFF;
            13: v = 33'sh00001FFFF;
            14: v = 33'sh00000FFFF;
            15: v = 33'sh000007FFF;
            16: v = 33'sh000003FFF;
            17: v = 33'sh000001FFF;
            18: v = 33'sh000000FFF;
            19: v = 33'sh0000007FF;
            20: v = 33'sh0000003FF;
            21: v = 33'sh0000001FF;
            22: v = 33'sh0000000FF;
            23: v = 33'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/euler_to_quaternion.sv =====
// Top level of the Euler angle (ZYX) to unit quaternion converter.
// Fully pipelined: a new request is taken every cycle unless the master side
// stalls, and each result passes through one fold stage, one CORDIC cell per
// iteration and four product and rounding stages ending in the output
// register. A stall on the master side freezes the whole pipeline; the
// slave side stays ready whenever the output register is empty or being taken.
`default_nettype none
module euler_to_quaternion #(
    parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,  // roll_angle, pitch_angle, yaw_angle
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata   // quat_w, quat_x, quat_y, quat_z
);
    import e2q_pkg::*;

    logic   w_en;
    t_lanes w_lanes [CORDIC_STEPS+1];
    logic   w_valid [CORDIC_STEPS+1];

    // Advance every stage unless a finished result is held
    assign w_en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    e2q_fold u_fold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_s_axis_tvalid),
        .i_angles (i_s_axis_tdata),
        .o_lanes  (w_lanes[0]),
        .o_valid  (w_valid[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        e2q_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_lanes (w_lanes[g]),
            .i_valid (w_valid[g]),
            .o_lanes (w_lanes[g+1]),
            .o_valid (w_valid[g+1])
        );
    end

    e2q_quat u_quat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_lanes (w_lanes[CORDIC_STEPS]),
        .i_valid (w_valid[CORDIC_STEPS]),
        .o_tdata (o_m_axis_tdata),
        .o_valid (o_m_axis_tvalid)
    );
endmodule
`default_nettype wire

// ===== hdl/e2q_fold.sv =====
// Input stage: halve each angle, fold it by quadrant and seed the rotation.
`default_nettype none
module e2q_fold (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [47:0]   i_angles,
    output e2q_pkg::t_lanes    o_lanes,
    output logic               o_valid
);
    import e2q_pkg::*;

    t_lanes r_lanes, n_lanes;
    logic   r_valid;

    // Fold each half angle into [-pi/2, pi/2]
    always_comb begin
        logic signed [33:0] z;
        for (int k = 0; k < 3; k++) begin
            z = 34'($signed(i_angles[16*k +: 16])) <<< 17;
            n_lanes[k].x = Q30_GAIN;
            n_lanes[k].y = '0;
            n_lanes[k].flip = 1'b0;
            if (z > Q30_HALF_PI) begin
                z = z - Q30_PI;
                n_lanes[k].flip = 1'b1;
            end else if (z < -Q30_HALF_PI) begin
                z = z + Q30_PI;
                n_lanes[k].flip = 1'b1;
            end
            n_lanes[k].z = z[ZW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lanes <= n_lanes;
        end
    end

    assign o_lanes = r_lanes;
    assign o_valid = r_valid;
endmodule
`default_nettype wire

// ===== hdl/e2q_cell.sv =====
// One rotation-mode CORDIC iteration for the three angle lanes.
`default_nettype none
module e2q_cell #(
    parameter int STEP = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  e2q_pkg::t_lanes    i_lanes,
    input  wire logic          i_valid,
    output e2q_pkg::t_lanes    o_lanes,
    output logic               o_valid
);
    import e2q_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = atan_q30(STEP);

    t_lanes r_lanes, n_lanes;
    logic   r_valid;

    // Rotate toward zero residual angle
    always_comb begin
        logic signed [ZW-1:0] dx, dy;
        for (int k = 0; k < 3; k++) begin
            dx = $signed(i_lanes[k].y) >>> STEP;
            dy = $signed(i_lanes[k].x) >>> STEP;
            n_lanes[k].flip = i_lanes[k].flip;
            if (!i_lanes[k].z[ZW-1]) begin
                n_lanes[k].x = i_lanes[k].x - dx;
                n_lanes[k].y = i_lanes[k].y + dy;
                n_lanes[k].z = i_lanes[k].z - ATAN;
            end else begin
                n_lanes[k].x = i_lanes[k].x + dx;
                n_lanes[k].y = i_lanes[k].y - dy;
                n_lanes[k].z = i_lanes[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lanes <= n_lanes;
        end
    end

    assign o_lanes = r_lanes;
    assign o_valid = r_valid;
endmodule
`default_nettype wire

// ===== hdl/e2q_quat.sv =====
// Output stages: round cos/sin, form the ZYX triple products, round and saturate.
`default_nettype none
module e2q_quat (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  e2q_pkg::t_lanes    i_lanes,
    input  wire logic          i_valid,
    output logic [63:0]        o_tdata,
    output logic               o_valid
);
    import e2q_pkg::*;

    logic signed [15:0] r_c [3], r_s [3];
    logic signed [31:0] r_crcp, r_srsp, r_srcp, r_crsp;
    logic signed [15:0] r_cy, r_sy;
    logic signed [47:0] r_p [8];
    logic [63:0]        r_tdata;
    logic [3:0]         r_valid;

    function automatic logic [15:0] finish(input logic signed [47:0] a,
                                           input logic signed [47:0] b);
        logic signed [47:0] s;
        logic signed [19:0] v;
        s = a + b + 48'sd134217728;
        v = 20'(s >>> 28);
        if (v > 20'sd16384) v = 20'sd16384;
        if (v < -20'sd16384) v = -20'sd16384;
        return v[15:0];
    endfunction

    // Advance the valid marks with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [ZW-1:0] rc, rs;
        if (i_en) begin
            // Round Q.30 to Q1.14 and undo the fold
            for (int k = 0; k < 3; k++) begin
                rc = (i_lanes[k].x + 33'sd32768) >>> 16;
                rs = (i_lanes[k].y + 33'sd32768) >>> 16;
                r_c[k] <= i_lanes[k].flip ? -rc[15:0] : rc[15:0];
                r_s[k] <= i_lanes[k].flip ? -rs[15:0] : rs[15:0];
            end
            // Roll and pitch pair products
            r_crcp <= 32'(r_c[0]) * 32'(r_c[1]);
            r_srsp <= 32'(r_s[0]) * 32'(r_s[1]);
            r_srcp <= 32'(r_s[0]) * 32'(r_c[1]);
            r_crsp <= 32'(r_c[0]) * 32'(r_s[1]);
            r_cy   <= r_c[2];
            r_sy   <= r_s[2];
            // Triple products
            r_p[0] <= 48'(r_crcp) * 48'(r_cy);
            r_p[1] <= 48'(r_srsp) * 48'(r_sy);
            r_p[2] <= 48'(r_srcp) * 48'(r_cy);
            r_p[3] <= 48'(r_crsp) * 48'(r_sy);
            r_p[4] <= 48'(r_crsp) * 48'(r_cy);
            r_p[5] <= 48'(r_srcp) * 48'(r_sy);
            r_p[6] <= 48'(r_crcp) * 48'(r_sy);
            r_p[7] <= 48'(r_srsp) * 48'(r_cy);
            // Combine, round and saturate into the output register
            r_tdata <= {finish(r_p[6], -r_p[7]), finish(r_p[4], r_p[5]),
                        finish(r_p[2], -r_p[3]), finish(r_p[0], r_p[1])};
        end
    end

    assign o_tdata = r_tdata;
    assign o_valid = r_valid[3];
endmodule
`default_nettype wire

// ===== hdl/euler_to_quaternion_checker.sv =====
// Port-level checker for the Euler to quaternion block, bound to the top level.
`default_nettype none
`include "euler_to_quaternion_defines.svh"
module euler_to_quaternion_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [47:0] i_s_axis_tdata,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [63:0] o_m_axis_tdata
);
    // Hold a stalled result
    `E2Q_ASSERT_NEXT(a_hold, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && o_m_axis_tvalid, "stalled result changed")
    // Take requests whenever the output is free
    `E2Q_ASSERT_NOW(a_ready, !o_m_axis_tvalid || i_m_axis_tready, o_s_axis_tready, "not ready with free output")
    // Keep every component within plus or minus one
    `E2Q_ASSERT_NOW(a_range, o_m_axis_tvalid, $signed(o_m_axis_tdata[15:0]) <= 16'sd16384 && $signed(o_m_axis_tdata[15:0]) >= -16'sd16384 && $signed(o_m_axis_tdata[31:16]) <= 16'sd16384 && $signed(o_m_axis_tdata[31:16]) >= -16'sd16384 && $signed(o_m_axis_tdata[47:32]) <= 16'sd16384 && $signed(o_m_axis_tdata[47:32]) >= -16'sd16384 && $signed(o_m_axis_tdata[63:48]) <= 16'sd16384 && $signed(o_m_axis_tdata[63:48]) >= -16'sd16384, "component out of range")
endmodule

bind euler_to_quaternion euler_to_quaternion_checker u_checker (.*);
`default_nettype wire
